// ===== design/alignment_coverage_depth_counter_defines.svh =====
// ----------------------------------------------------------------------------
// Alignment coverage depth counter - assertion macros
// Shared property wrappers for the checker, clocked on i_clk and held off
// while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ALIGNMENT_COVERAGE_DEPTH_COUNTER_DEFINES_SVH
`define ALIGNMENT_COVERAGE_DEPTH_COUNTER_DEFINES_SVH

// same-cycle implication
`define ACDC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACDC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/acdc_pkg.sv =====
// ----------------------------------------------------------------------------
// acdc_pkg
// Constants, codes and controller/datapath interface types of the
// alignment coverage depth counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acdc_pkg;

    // depth store geometry
    localparam int MAX_POSITIONS = 65536;
    localparam int ADDR_W        = $clog2(MAX_POSITIONS);
    localparam int POS_W         = ADDR_W + 1;

    // field widths
    localparam int DEPTH_W   = 32;
    localparam int CURSOR_W  = 40;
    localparam int START_W   = 32;
    localparam int OPCODE_W  = 4;
    localparam int OPLEN_W   = 28;
    localparam int QUERY_W   = 16;
    localparam int REFLEN_W  = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 17;

    localparam logic [DEPTH_W-1:0]  DEPTH_MAX  = '1;
    localparam logic [CURSOR_W-1:0] CURSOR_MAX = {1'b0, {(CURSOR_W-1){1'b1}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_DEL  = 1'd1;

    // CIGAR operation codes
    localparam logic [OPCODE_W-1:0] OP_M  = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_D  = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_N  = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_EQ = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_X  = 4'd8;

    // item kinds
    localparam logic ACT_APPLY = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // controller commands
    typedef struct packed {
        logic clear;
        logic accept;
        logic setup;
        logic walk;
        logic load_out;
    } t_ctrl;

    // datapath status
    typedef struct packed {
        logic clear_done;
        logic walk_done;
        logic out_free;
    } t_stat;

endpackage

// ===== design/acdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// acdc_ctrl
// Sequencer: clearing pass after reset, then items one at a time, operations
// via span setup, position walk and result hand-off, queries via hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acdc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_action,
    input  acdc_pkg::t_stat i_stat,
    output acdc_pkg::t_ctrl o_ctrl,
    output logic           o_in_ready
);
    import acdc_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_ctrl.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.accept = 1'b1;
                    n_state = (i_action == ACT_QUERY) ? ST_FINISH : ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_ctrl.setup = 1'b1;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                o_ctrl.walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_ctrl.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/acdc_datapath.sv =====
// ----------------------------------------------------------------------------
// acdc_datapath
// Depth store, reference cursor, span clamping, read-modify-write walk and
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acdc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  acdc_pkg::t_ctrl                   i_ctrl,
    output acdc_pkg::t_stat                   o_stat,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [acdc_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [acdc_pkg::CFG_DAT_W-1:0]    i_cfg_wdata,
    // input item
    input  logic                              i_action,
    input  logic                              i_first_op,
    input  logic [acdc_pkg::START_W-1:0]      i_start_position,
    input  logic [acdc_pkg::OPCODE_W-1:0]     i_op_code,
    input  logic [acdc_pkg::OPLEN_W-1:0]      i_op_length,
    input  logic [acdc_pkg::QUERY_W-1:0]      i_query_index,
    // result item
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [acdc_pkg::DEPTH_W-1:0]      o_depth_value,
    output logic                              o_overflow,
    output logic                              o_any_reads
);
    import acdc_pkg::*;

    // configuration registers
    logic [REFLEN_W-1:0] r_cfg_len;
    logic                r_cfg_del;

    // item state
    logic signed [CURSOR_W-1:0] r_cursor;
    logic                       r_seen;
    logic                       r_action;
    logic [OPCODE_W-1:0]        r_code;
    logic [OPLEN_W-1:0]         r_len;
    logic                       r_q_ok;
    logic                       r_ovf;

    // walk state
    logic [POS_W-1:0]  r_addr;
    logic [POS_W-1:0]  r_end;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_rd_pend;
    logic [DEPTH_W-1:0] r_rd_data;

    // output register
    logic               r_out_valid;
    logic [DEPTH_W-1:0] r_out_depth;
    logic               r_out_ovf;
    logic               r_out_any;

    // depth store
    logic [DEPTH_W-1:0] r_mem [MAX_POSITIONS];

    logic [31:0]                w_len32;
    logic [POS_W-1:0]           w_lim;
    logic signed [CURSOR_W:0]   w_sum;
    logic [CURSOR_W-1:0]        w_cur_next;
    logic [POS_W-1:0]           w_start;
    logic [POS_W-1:0]           w_stop;
    logic                       w_is_count;
    logic                       w_is_adv;
    logic                       w_sat;
    logic                       w_more;
    logic                       w_issue;
    logic                       w_out_free;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_wa;
    logic [DEPTH_W-1:0]         mem_wd;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_ra;

    // active limit: ref_length capped at the store size
    assign w_len32 = 32'(r_cfg_len);
    assign w_lim   = (w_len32 > 32'(MAX_POSITIONS)) ? POS_W'(MAX_POSITIONS)
                                                    : POS_W'(r_cfg_len);

    // op classes
    assign w_is_count = (r_code == OP_M) || (r_code == OP_EQ) || (r_code == OP_X) ||
                        ((r_code == OP_D) && r_cfg_del);
    assign w_is_adv   = (r_code == OP_M) || (r_code == OP_EQ) || (r_code == OP_X) ||
                        (r_code == OP_D) || (r_code == OP_N);

    // span end and saturating cursor advance
    assign w_sum = $signed({r_cursor[CURSOR_W-1], r_cursor}) +
                   $signed({{(CURSOR_W+1-OPLEN_W){1'b0}}, r_len});
    assign w_cur_next = (!w_sum[CURSOR_W] && w_sum[CURSOR_W-1]) ? CURSOR_MAX
                                                                : w_sum[CURSOR_W-1:0];

    // clamp span to [0, limit)
    always_comb begin
        if (r_cursor[CURSOR_W-1]) begin
            w_start = '0;
        end else if (r_cursor >= $signed(CURSOR_W'(w_lim))) begin
            w_start = w_lim;
        end else begin
            w_start = r_cursor[POS_W-1:0];
        end
        if (w_sum[CURSOR_W]) begin
            w_stop = '0;
        end else if (w_sum >= $signed((CURSOR_W+1)'(w_lim))) begin
            w_stop = w_lim;
        end else begin
            w_stop = w_sum[POS_W-1:0];
        end
    end

    // walk: check the word read last cycle, read the next one
    assign w_sat   = r_rd_pend && (r_rd_data == DEPTH_MAX);
    assign w_more  = r_addr < r_end;
    assign w_issue = i_ctrl.walk && !w_sat && w_more;

    // memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wr_addr;
        mem_wd = r_rd_data + 32'd1;
        mem_re = 1'b0;
        mem_ra = r_addr[ADDR_W-1:0];
        if (i_ctrl.clear) begin
            mem_we = 1'b1;
            mem_wa = r_addr[ADDR_W-1:0];
            mem_wd = '0;
        end else if (i_ctrl.walk) begin
            mem_we = r_rd_pend && !w_sat;
        end
        if (i_ctrl.accept && (i_action == ACT_QUERY)) begin
            mem_re = 1'b1;
            mem_ra = ADDR_W'(i_query_index);
        end else if (w_issue) begin
            mem_re = 1'b1;
        end
    end

    // depth store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len   <= REFLEN_W'(MAX_POSITIONS);
            r_cfg_del   <= 1'b1;
            r_cursor    <= '0;
            r_seen      <= 1'b0;
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_REF_LENGTH: r_cfg_len <= i_cfg_wdata[REFLEN_W-1:0];
                    CFG_COUNT_DEL:  r_cfg_del <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_ctrl.clear) begin
                r_addr <= r_addr + POS_W'(1);
            end
            if (i_ctrl.accept && (i_action == ACT_APPLY)) begin
                r_seen <= 1'b1;
                if (i_first_op) begin
                    r_cursor <= $signed({{(CURSOR_W-START_W){1'b0}}, i_start_position}) -
                                $signed(CURSOR_W'(1));
                end
            end
            if (i_ctrl.setup) begin
                r_addr    <= w_start;
                r_rd_pend <= 1'b0;
                if (w_is_adv) begin
                    r_cursor <= w_cur_next;
                end
            end
            if (i_ctrl.walk) begin
                if (w_sat) begin
                    r_addr    <= r_end;
                    r_rd_pend <= 1'b0;
                end else if (w_issue) begin
                    r_addr    <= r_addr + POS_W'(1);
                    r_rd_pend <= 1'b1;
                end else begin
                    r_rd_pend <= 1'b0;
                end
            end
            if (i_ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_action <= i_action;
            r_code   <= i_op_code;
            r_len    <= i_op_length;
            r_q_ok   <= 32'(i_query_index) < 32'(MAX_POSITIONS);
            r_ovf    <= 1'b0;
        end
        if (i_ctrl.setup) begin
            r_end <= w_is_count ? w_stop : w_start;
        end
        if (i_ctrl.walk) begin
            if (w_sat) begin
                r_ovf <= 1'b1;
            end else if (w_issue) begin
                r_wr_addr <= r_addr[ADDR_W-1:0];
            end
        end
        if (i_ctrl.load_out) begin
            r_out_depth <= ((r_action == ACT_QUERY) && r_q_ok) ? r_rd_data : '0;
            r_out_ovf   <= (r_action == ACT_APPLY) && r_ovf;
            r_out_any   <= r_seen;
        end
    end

    // status
    assign o_stat.clear_done = (r_addr == POS_W'(MAX_POSITIONS - 1));
    assign o_stat.walk_done  = !r_rd_pend && !w_more;
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid   = r_out_valid;
    assign o_depth_value = r_out_depth;
    assign o_overflow    = r_out_ovf;
    assign o_any_reads   = r_out_any;

endmodule

// ===== design/alignment_coverage_depth_counter.sv =====
// Alignment coverage depth counter. Keeps a 32-bit read depth for each of
// 65536 reference positions and applies CIGAR operations one item at a time
// (M, = and X count over their span, D counts when enabled, N only moves the
// cursor); query items return the depth of one position. After reset the
// store is cleared by a pass over every word, one word a cycle, during which
// s_axis_tready stays low; configuration writes are taken throughout. An
// operation item goes through span setup and then walks its clamped span,
// stopping early on a saturated position; an operation that counts nothing,
// or whose span clamps to empty, walks no positions. The span is walked one
// position a cycle through the store's registered read port and its write
// port. A query item goes from acceptance straight to result hand-off. The
// result sits in an output register, so the next item is taken while the
// previous result waits on m_axis_tready; that item's own result is held
// back until the earlier one has left.
`timescale 1ns / 1ps

module alignment_coverage_depth_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [acdc_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [acdc_pkg::CFG_DAT_W-1:0]    i_cfg_wdata,
    // item input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] first_op, [32:1] start_position, [36:33] op_code,
    // [64:37] op_length, [80:65] query_index, [87:81] zero
    input  logic [87:0] s_axis_tdata,
    // [0] action
    input  logic        s_axis_tuser,
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] depth_value, [32] overflow, [33] any_reads, [39:34] zero
    output logic [39:0] m_axis_tdata
);
    import acdc_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    logic [DEPTH_W-1:0] w_depth;
    logic               w_ovf;
    logic               w_any;

    acdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_action   (s_axis_tuser),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl),
        .o_in_ready (s_axis_tready)
    );

    acdc_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (w_ctrl),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_action         (s_axis_tuser),
        .i_first_op       (s_axis_tdata[0]),
        .i_start_position (s_axis_tdata[32:1]),
        .i_op_code        (s_axis_tdata[36:33]),
        .i_op_length      (s_axis_tdata[64:37]),
        .i_query_index    (s_axis_tdata[80:65]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_depth_value    (w_depth),
        .o_overflow       (w_ovf),
        .o_any_reads      (w_any)
    );

    // result packing
    assign m_axis_tdata = {6'b0, w_any, w_ovf, w_depth};

endmodule

// ===== design/acdc_checker.sv =====
// ----------------------------------------------------------------------------
// acdc_checker
// Port-level checks of the alignment coverage depth counter, bound to the
// top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alignment_coverage_depth_counter_defines.svh"

module acdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // a stalled result holds
    `ACDC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // overflow only on op items, which carry zero depth
    `ACDC_ASSERT_IMP(a_ovf_depth, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[31:0] == 32'd0, "overflow with nonzero depth")

    // overflow implies an op has been seen
    `ACDC_ASSERT_IMP(a_ovf_any, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[33], "overflow without any_reads")

    // one item at a time
    `ACDC_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item taken while busy")

    // clearing pass follows reset
    `ACDC_ASSERT_IMP(a_clear_busy, $past(!i_rst_n), !s_axis_tready, "ready during clearing pass")

endmodule

bind alignment_coverage_depth_counter acdc_checker u_acdc_checker (.*);
